/* sv/hts_pkg.sv */
// shared types, constants and marker matchers for the html tag stripper
`default_nettype none

package hts_pkg;

  localparam int unsigned NAME_MAX_DEF = 16384;

  // characters
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // tag name hashes of the special tags
  localparam logic [31:0] HASH_COMMENT = 32'd441;
  localparam logic [31:0] HASH_SCRIPT  = 32'd3052;
  localparam logic [31:0] HASH_STYLE   = 32'd2268;

  // closing markers, lower case
  localparam int unsigned CMT_LEN = 3;
  localparam int unsigned SCR_LEN = 8;
  localparam int unsigned STY_LEN = 7;
  localparam logic [7:0] CMT_PAT [0:CMT_LEN-1] = '{8'h2d, 8'h2d, 8'h3e};
  localparam logic [7:0] SCR_PAT [0:SCR_LEN-1] =
    '{8'h2f, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h3e};
  localparam logic [7:0] STY_PAT [0:STY_LEN-1] =
    '{8'h2f, 8'h73, 8'h74, 8'h79, 8'h6c, 8'h65, 8'h3e};

  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_NAME    = 2'd1,
    MODE_BODY    = 2'd2,
    MODE_SPECIAL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_COMMENT = 2'd1,
    KIND_SCRIPT  = 2'd2,
    KIND_STYLE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0] clean_byte;
    logic       was_blanked;
    logic       last_out;
  } result_t;

  typedef struct packed {
    logic       done;
    logic [1:0] st;
  } cmt_match_t;

  typedef struct packed {
    logic       done;
    logic [3:0] st;
  } scr_match_t;

  typedef struct packed {
    logic       done;
    logic [2:0] st;
  } sty_match_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5a]}) r = c + 8'h20;
    return r;
  endfunction

  // "-->": a dash after a partial "--" keeps the partial match
  function automatic cmt_match_t cmt_step(input logic [1:0] st, input logic [7:0] c);
    cmt_match_t r;
    logic [1:0] idx;
    idx = (st == 2'(CMT_LEN)) ? 2'd0 : st;
    r.done = 1'b0;
    r.st = 2'd0;
    if (c == CMT_PAT[idx]) begin
      if (idx == 2'(CMT_LEN - 1)) r.done = 1'b1;
      else r.st = idx + 2'd1;
    end else if (c == CH_DASH) begin
      r.st = (idx == 2'(CMT_LEN - 1)) ? 2'(CMT_LEN - 1) : 2'd1;
    end
    return r;
  endfunction

  // "/script>": the slash occurs only once, so a miss falls back to it or to zero
  function automatic scr_match_t scr_step(input logic [3:0] st, input logic [7:0] c);
    scr_match_t r;
    logic [2:0] idx;
    idx = st[3] ? 3'd0 : st[2:0];
    r.done = 1'b0;
    r.st = 4'd0;
    if (c == SCR_PAT[idx]) begin
      if (idx == 3'(SCR_LEN - 1)) r.done = 1'b1;
      else r.st = {1'b0, idx} + 4'd1;
    end else if (c == CH_SLASH) begin
      r.st = 4'd1;
    end
    return r;
  endfunction

  // "/style>": same shape as the script marker
  function automatic sty_match_t sty_step(input logic [2:0] st, input logic [7:0] c);
    sty_match_t r;
    logic [2:0] idx;
    idx = (st == 3'(STY_LEN)) ? 3'd0 : st;
    r.done = 1'b0;
    r.st = 3'd0;
    if (c == STY_PAT[idx]) begin
      if (idx == 3'(STY_LEN - 1)) r.done = 1'b1;
      else r.st = idx + 3'd1;
    end else if (c == CH_SLASH) begin
      r.st = 3'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/hts_if.sv */
// valid/ready channel interfaces for text words in and cleaned words out
`default_nettype none

interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       was_blanked;
  logic       last_out;
  modport source (output valid, output clean_byte, output was_blanked, output last_out,
                  input ready);
  modport sink (input valid, input clean_byte, input was_blanked, input last_out,
                output ready);
endinterface

`default_nettype wire

/* sv/hts_parser.sv */
// tag parser state machine: mode, tag kind, name hash and marker matchers
`default_nettype none

module hts_parser #(
  parameter int unsigned NAME_MAX = hts_pkg::NAME_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  hts_pkg::item_t item,
  output logic          blank
);
  import hts_pkg::*;

  localparam int unsigned POS_W = $clog2(NAME_MAX + 1);

  mode_t            mode_r, mode_nxt;
  kind_t            kind_r, kind_nxt;
  logic [31:0]      hash_r, hash_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       cmt_r, cmt_nxt;
  logic [3:0]       scr_r, scr_nxt;
  logic [2:0]       sty_r, sty_nxt;

  logic [7:0]       lc;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W+7:0] prod;
  cmt_match_t       cmt_res;
  scr_match_t       scr_res;
  sty_match_t       sty_res;
  logic             fin;
  logic             delim;

  assign lc      = to_lower(item.text_byte);
  assign cmt_res = cmt_step(cmt_r, lc);
  assign scr_res = scr_step(scr_r, lc);
  assign sty_res = sty_step(sty_r, lc);
  assign pos_inc = pos_r + POS_W'(1);
  assign prod    = pos_inc * item.text_byte;
  assign delim   = (item.text_byte == CH_SP) || (item.text_byte == CH_GT);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    kind_nxt = kind_r;
    hash_nxt = hash_r;
    pos_nxt  = pos_r;
    cmt_nxt  = cmt_r;
    scr_nxt  = scr_r;
    sty_nxt  = sty_r;
    fin      = 1'b0;
    case (mode_r)
      MODE_TEXT: begin
        if (item.text_byte == CH_LT) begin
          cmt_nxt  = '0;
          scr_nxt  = '0;
          sty_nxt  = '0;
          kind_nxt = KIND_NONE;
          pos_nxt  = POS_W'(1);
          hash_nxt = 32'(CH_LT);
          mode_nxt = MODE_NAME;
        end
      end
      MODE_NAME: begin
        cmt_nxt = cmt_res.st;
        scr_nxt = scr_res.st;
        sty_nxt = sty_res.st;
        if (delim) begin
          if (hash_r == HASH_COMMENT) kind_nxt = KIND_COMMENT;
          else if (hash_r == HASH_SCRIPT) kind_nxt = KIND_SCRIPT;
          else if (hash_r == HASH_STYLE) kind_nxt = KIND_STYLE;
          else kind_nxt = KIND_NONE;
          case (kind_nxt)
            KIND_COMMENT: fin = cmt_res.done;
            KIND_SCRIPT:  fin = scr_res.done;
            KIND_STYLE:   fin = sty_res.done;
            default:      fin = (item.text_byte == CH_GT);
          endcase
          if (fin) mode_nxt = MODE_TEXT;
          else if (kind_nxt == KIND_NONE) mode_nxt = MODE_BODY;
          else mode_nxt = MODE_SPECIAL;
        end else if (pos_r < POS_W'(NAME_MAX)) begin
          pos_nxt  = pos_inc;
          hash_nxt = hash_r + 32'(prod);
        end
      end
      MODE_BODY: begin
        if (item.text_byte == CH_GT) mode_nxt = MODE_TEXT;
      end
      MODE_SPECIAL: begin
        case (kind_r)
          KIND_COMMENT: begin
            cmt_nxt = cmt_res.st;
            fin     = cmt_res.done;
          end
          KIND_SCRIPT: begin
            scr_nxt = scr_res.st;
            fin     = scr_res.done;
          end
          KIND_STYLE: begin
            sty_nxt = sty_res.st;
            fin     = sty_res.done;
          end
          default: fin = 1'b1;
        endcase
        if (fin) mode_nxt = MODE_TEXT;
      end
      default: mode_nxt = MODE_TEXT;
    endcase
    if (mode_nxt == MODE_TEXT) begin
      kind_nxt = KIND_NONE;
      cmt_nxt  = '0;
      scr_nxt  = '0;
      sty_nxt  = '0;
    end
    if (item.end_of_text) begin
      mode_nxt = MODE_TEXT;
      kind_nxt = KIND_NONE;
      hash_nxt = '0;
      pos_nxt  = '0;
      cmt_nxt  = '0;
      scr_nxt  = '0;
      sty_nxt  = '0;
    end
  end

  // outputs
  always_comb begin
    blank = (mode_r != MODE_TEXT) || (item.text_byte == CH_LT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      kind_r <= KIND_NONE;
      hash_r <= '0;
      pos_r  <= '0;
      cmt_r  <= '0;
      scr_r  <= '0;
      sty_r  <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      kind_r <= kind_nxt;
      hash_r <= hash_nxt;
      pos_r  <= pos_nxt;
      cmt_r  <= cmt_nxt;
      scr_r  <= scr_nxt;
      sty_r  <= sty_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/hts_out_reg.sv */
// result register driving the output channel
`default_nettype none

module hts_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hts_pkg::result_t res,
  output logic             can_load,
  hts_out_if.source        out_chan
);
  import hts_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign can_load             = !valid_r || out_chan.ready;
  assign out_chan.valid       = valid_r;
  assign out_chan.clean_byte  = res_r.clean_byte;
  assign out_chan.was_blanked = res_r.was_blanked;
  assign out_chan.last_out    = res_r.last_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

/* sv/html_tag_stripper.sv */
// top level of the html tag stripper
`default_nettype none

// Streams page text one byte per word and returns every byte either as it
// came or as a space when it falls inside markup. A '<' opens a tag whose
// name runs to the first space or '>'; comment, script and style tags (told
// apart by a position-weighted hash of the name) are blanked through their
// case-insensitive closing marker, any other tag through the next '>'. An
// open tag at end_of_text is blanked to the last byte and the parser then
// starts afresh. One word is taken every clock while the sink keeps up, and
// each word gives exactly one result word. A word is held in the input
// register and then in the output register; the parser state loop updates
// for a byte as it moves. The input register is freed as its word moves
// into the output register, so a new word is taken while a finished
// result still waits for the sink.

module html_tag_stripper #(
  parameter int unsigned NAME_MAX = hts_pkg::NAME_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hts_in_if.sink    in_chan,
  hts_out_if.source out_chan
);
  import hts_pkg::*;

  // input register
  logic    in_valid_r;
  item_t   item_r;

  // handshake between the stages
  logic    can_load;
  logic    step_go;
  logic    blank;
  result_t res;

  // a word moves on when the result register is free or being emptied
  assign step_go       = in_valid_r && can_load;
  assign in_chan.ready = !in_valid_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (step_go) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.text_byte   <= in_chan.text_byte;
      item_r.end_of_text <= in_chan.end_of_text;
    end
  end

  // parser state advances once per word passed on
  hts_parser #(
    .NAME_MAX (NAME_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_go),
    .item    (item_r),
    .blank   (blank)
  );

  // blanked bytes become spaces
  always_comb begin
    res.clean_byte  = blank ? CH_SP : item_r.text_byte;
    res.was_blanked = blank;
    res.last_out    = item_r.end_of_text;
  end

  hts_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step_go),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

/* bench/html_tag_stripper_test.sv */
// self-checking bench for html_tag_stripper: paced text words in, cleaned words checked
module html_tag_stripper_test;
  import hts_pkg::*;

  // a small name limit keeps the long-name case cheap to reach
  localparam int unsigned NAME_LIMIT = 16;
  localparam int unsigned STIM_BYTES = 1560;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_ALTERNATE,
    READY_RANDOM,
    READY_BURSTY
  } ready_pattern_t;

  logic clk = 1'b0;
  logic rst_n;

  hts_in_if in_if ();
  hts_out_if out_if ();

  html_tag_stripper #(
    .NAME_MAX(NAME_LIMIT)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // words still to send, and cleaned words still owed by the block
  item_t page_bytes[$];
  result_t clean_expected[$];

  // local copy of the parser state
  mode_t strip_mode;
  kind_t strip_kind;
  logic [31:0] strip_hash;
  logic [14:0] strip_pos;
  logic [1:0] strip_cmt;
  logic [3:0] strip_scr;
  logic [2:0] strip_sty;

  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  logic stuck = 1'b0;
  logic in_took = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [7:0] rx_tick = 8'd0;
  ready_pattern_t ready_pattern = READY_ALWAYS;

  function automatic void strip_clear();
    strip_mode = MODE_TEXT;
    strip_kind = KIND_NONE;
    strip_hash = 32'd0;
    strip_pos = 15'd0;
    strip_cmt = 2'd0;
    strip_scr = 4'd0;
    strip_sty = 3'd0;
  endfunction

  // longest prefix of the marker that ends at this byte; a full match resets to zero
  function automatic int unsigned marker_advance(input int unsigned st, input logic [7:0] c,
                                                 input string pat, output logic hit);
    int unsigned len;
    int unsigned k;
    int unsigned i;
    logic ok;
    hit = 1'b0;
    len = pat.len();
    if (st >= len) st = 0;
    for (k = st + 1; k > 0; k--) begin
      ok = (pat[k-1] == c);
      for (i = 0; i + 1 < k; i++) begin
        if (pat[i] != pat[st-(k-1)+i]) ok = 1'b0;
      end
      if (ok) begin
        if (k == len) begin
          hit = 1'b1;
          return 0;
        end
        return k;
      end
    end
    return 0;
  endfunction

  // expected cleaned word for one text word, advancing the local parser state
  function automatic result_t strip_predict(input logic [7:0] c, input logic last);
    result_t r;
    logic [7:0] lc;
    logic blank;
    logic hit_c;
    logic hit_s;
    logic hit_y;
    logic fin;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    blank = 1'b0;
    hit_c = 1'b0;
    hit_s = 1'b0;
    hit_y = 1'b0;
    fin = 1'b0;
    case (strip_mode)
      MODE_TEXT: begin
        if (c == CH_LT) begin
          blank = 1'b1;
          strip_cmt = 2'd0;
          strip_scr = 4'd0;
          strip_sty = 3'd0;
          strip_kind = KIND_NONE;
          strip_pos = 15'd1;
          strip_hash = 32'(CH_LT);
          strip_mode = MODE_NAME;
        end
      end
      MODE_NAME: begin
        blank = 1'b1;
        // markers are tracked from the '<' on, so they may overlap the name
        strip_cmt = 2'(marker_advance(strip_cmt, lc, "-->", hit_c));
        strip_scr = 4'(marker_advance(strip_scr, lc, "/script>", hit_s));
        strip_sty = 3'(marker_advance(strip_sty, lc, "/style>", hit_y));
        if (c == CH_SP || c == CH_GT) begin
          if (strip_hash == HASH_COMMENT) strip_kind = KIND_COMMENT;
          else if (strip_hash == HASH_SCRIPT) strip_kind = KIND_SCRIPT;
          else if (strip_hash == HASH_STYLE) strip_kind = KIND_STYLE;
          else strip_kind = KIND_NONE;
          if (strip_kind == KIND_NONE) begin
            strip_mode = (c == CH_GT) ? MODE_TEXT : MODE_BODY;
          end else begin
            fin = (strip_kind == KIND_COMMENT) ? hit_c :
                  (strip_kind == KIND_SCRIPT) ? hit_s : hit_y;
            strip_mode = fin ? MODE_TEXT : MODE_SPECIAL;
          end
        end else if (strip_pos < NAME_LIMIT) begin
          // bytes past the limit stay in the name but leave the hash alone
          strip_pos = strip_pos + 15'd1;
          strip_hash = strip_hash + 32'(strip_pos) * 32'(c);
        end
      end
      MODE_BODY: begin
        blank = 1'b1;
        if (c == CH_GT) strip_mode = MODE_TEXT;
      end
      default: begin
        blank = 1'b1;
        case (strip_kind)
          KIND_COMMENT: strip_cmt = 2'(marker_advance(strip_cmt, lc, "-->", fin));
          KIND_SCRIPT: strip_scr = 4'(marker_advance(strip_scr, lc, "/script>", fin));
          KIND_STYLE: strip_sty = 3'(marker_advance(strip_sty, lc, "/style>", fin));
          default: fin = 1'b1;
        endcase
        if (fin) strip_mode = MODE_TEXT;
      end
    endcase
    if (strip_mode == MODE_TEXT) begin
      strip_kind = KIND_NONE;
      strip_cmt = 2'd0;
      strip_scr = 4'd0;
      strip_sty = 3'd0;
    end
    // the parser starts afresh after the final byte of a page
    if (last) strip_clear();
    r.clean_byte = blank ? CH_SP : c;
    r.was_blanked = blank;
    r.last_out = last;
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    item_t w;
    w.text_byte = b;
    w.end_of_text = 1'b0;
    page_bytes.push_back(w);
  endtask

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // lower-case letters in the marker may come out in either case
  task automatic put_mixed(input string s);
    int i;
    logic [7:0] b;
    for (i = 0; i < s.len(); i++) begin
      b = s[i];
      if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1) == 1) b = b - 8'h20;
      put_byte(b);
    end
  endtask

  task automatic put_letters(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    logic [7:0] b;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      b = 8'($urandom_range(8'h61, 8'h7a));
      if ($urandom_range(0, 4) == 0) b = b - 8'h20;
      put_byte(b);
    end
  endtask

  task automatic put_text();
    int unsigned n;
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: put_byte(8'($urandom_range(0, 255)));
        1: put_byte(CH_SP);
        default: put_letters(1, 1);
      endcase
    end
  endtask

  // region content rich in near misses of the closing markers
  task automatic put_filler();
    int unsigned n;
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 8))
        0: put_str("-");
        1: put_str("--");
        2: put_mixed("/scri");
        3: put_mixed("/sty");
        4: put_byte(CH_SLASH);
        5: put_byte(CH_GT);
        6: put_byte(CH_LT);
        7: put_byte(8'($urandom_range(0, 255)));
        default: put_letters(1, 5);
      endcase
    end
  endtask

  task automatic put_plain_tag();
    put_byte(CH_LT);
    if ($urandom_range(0, 3) == 0) put_byte(CH_SLASH);
    if ($urandom_range(0, 7) == 0) put_letters(NAME_LIMIT - 2, NAME_LIMIT + 8);
    else put_letters(1, 6);
    if ($urandom_range(0, 1) == 1) begin
      put_byte(CH_SP);
      put_letters(1, 5);
      put_str("=\"-/x\"");
    end
    put_byte(CH_GT);
  endtask

  task automatic end_page();
    page_bytes[page_bytes.size()-1].end_of_text = 1'b1;
  endtask

  task automatic add_page();
    int unsigned segs;
    segs = $urandom_range(1, 8);
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0, 1, 2: put_text();
        3, 4: put_plain_tag();
        5: begin
          put_str("<!--");
          put_byte(($urandom_range(0, 1) == 1) ? CH_SP : CH_GT);
          put_filler();
          put_str("-->");
        end
        6: begin
          if ($urandom_range(0, 1) == 1) put_str("<script>");
          else put_str("<script type=js>");
          put_filler();
          put_byte(CH_LT);
          put_mixed("/script>");
        end
        7: begin
          if ($urandom_range(0, 1) == 1) put_str("<style>");
          else put_str("<style a=b>");
          put_filler();
          put_byte(CH_LT);
          put_mixed("/style>");
        end
        8: begin
          // names close to the special ones that must not count as special
          case ($urandom_range(0, 3))
            0: put_str("<SCRIPT>");
            1: put_str("<scrip>");
            2: put_str("<!-x>");
            default: put_str("<Style>");
          endcase
          put_filler();
        end
        default: begin
          repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // now and then a page stops inside an open tag or region
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          put_byte(CH_LT);
          put_letters(1, 6);
        end
        1: begin
          put_str("<script>");
          put_letters(1, 4);
        end
        2: begin
          put_str("<!-- ");
          put_letters(0, 4);
        end
        default: begin
          put_str("<p ");
          put_letters(1, 4);
        end
      endcase
    end else begin
      put_text();
    end
    end_page();
  endtask

  task automatic build_directed();
    // plain tag between text, and both byte extremes as text
    put_str("a<b>c");
    put_byte(8'hff);
    put_byte(8'h00);
    // comment whose name already holds the closing marker
    put_str("<!-->");
    // case-insensitive marker search, case-sensitive hash
    put_str("<script>x</SCRIPT>");
    put_str("<Script>y");
    put_str("<style a>-</StYlE>");
    put_str("<B c>");
    // long name padded with zero bytes still hashes as a comment
    put_str("<!--");
    repeat (NAME_LIMIT - 4) put_byte(8'h00);
    put_str("q-->");
    // script left open at the end of the page
    put_str("<script>ab");
    end_page();
    put_str("z");
    end_page();
  endtask

  // sender: bursts of random length with random gaps, changes on the falling edge
  always @(negedge clk) begin : drive_text
    item_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (page_bytes.size() != 0) begin
        w = page_bytes.pop_front();
        in_if.valid <= 1'b1;
        in_if.text_byte <= w.text_byte;
        in_if.end_of_text <= w.end_of_text;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches whenever the low six bits of its tick counter are zero
  always @(negedge clk) begin : drive_ready
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) ready_pattern <= ready_pattern_t'($urandom_range(0, 3));
    case (ready_pattern)
      READY_ALWAYS: out_if.ready <= 1'b1;
      READY_ALTERNATE: out_if.ready <= rx_tick[0];
      READY_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
      default: out_if.ready <= (rx_tick[2:0] >= 3'd5);
    endcase
  end

  // check finished words first, then record the word taken at this edge
  always @(posedge clk) begin : check_words
    result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      strip_clear();
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (clean_expected.size() == 0) begin
          $error("unexpected word: clean_byte %0d", out_if.clean_byte);
          err_count = err_count + 1;
        end else begin
          want = clean_expected.pop_front();
          if (out_if.clean_byte !== want.clean_byte) begin
            $error("clean_byte: expected %0d, got %0d", want.clean_byte, out_if.clean_byte);
            err_count = err_count + 1;
          end
          if (out_if.was_blanked !== want.was_blanked) begin
            $error("was_blanked: expected %0d, got %0d", want.was_blanked,
                   out_if.was_blanked);
            err_count = err_count + 1;
          end
          if (out_if.last_out !== want.last_out) begin
            $error("last_out: expected %0d, got %0d", want.last_out, out_if.last_out);
            err_count = err_count + 1;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        clean_expected.push_back(strip_predict(in_if.text_byte, in_if.end_of_text));
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      stuck <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    in_if.valid = 1'b0;
    in_if.text_byte = 8'd0;
    in_if.end_of_text = 1'b0;
    out_if.ready = 1'b0;
    rst_n = 1'b0;
    build_directed();
    while (page_bytes.size() < STIM_BYTES) add_page();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (stuck || (page_bytes.size() == 0 && !in_if.valid && clean_expected.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stuck || err_count != 0 || clean_expected.size() != 0) begin
      $display("html_tag_stripper_test: done, errors");
    end else begin
      $display("html_tag_stripper_test: done, clean");
    end
    $finish;
  end

endmodule
